FILE: hdl/ist_pkg.sv
// shared types and constants of the integer set table
package ist_pkg;

  parameter int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ElemW  = 32;
  localparam int unsigned CountW = 7;

  localparam logic [OpW-1:0] OP_ADD    = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic              was_member;
    logic [CountW-1:0] member_count;
    logic              set_empty;
    logic              overflow;
  } result_t;

endpackage

FILE: hdl/ist_if.sv
// request and result channel interfaces of the integer set table
interface ist_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] element;

  modport source (output valid, output operation, output element, input ready);
  modport sink   (input valid, input operation, input element, output ready);
endinterface

interface ist_out_if;
  logic       valid;
  logic       ready;
  logic       was_member;
  logic [6:0] member_count;
  logic       set_empty;
  logic       overflow;

  modport source (output valid, output was_member, output member_count,
                  output set_empty, output overflow, input ready);
  modport sink   (input valid, input was_member, input member_count,
                  input set_empty, input overflow, output ready);
endinterface

FILE: hdl/ist_result_reg.sv
// output register that holds one result transaction until it is taken
module ist_result_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ist_pkg::result_t res_i,
  output logic            can_load_o,
  ist_out_if.source       out_o
);
  import ist_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign can_load_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (out_o.ready) begin
      vld_d = 1'b0;
    end
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.was_member   = res_q.was_member;
  assign out_o.member_count = res_q.member_count;
  assign out_o.set_empty    = res_q.set_empty;
  assign out_o.overflow     = res_q.overflow;

endmodule

FILE: hdl/integer_set_table_top.sv
// integer set table: set of distinct 32-bit values kept packed in a one-read one-write memory
//
// Each request adds, removes or looks up one value and yields one result with the prior
// membership, the new count, an empty flag and an overflow flag for an add into a full
// table. A sequencer walks the stored entries through the memory's one read port, one
// entry per cycle, comparing each against the request. A remove then moves every later
// entry down one place, again one entry per cycle on the same port. A new request is
// taken once the previous one has reached the output register; results waiting there do
// not stall the search.
module integer_set_table_top #(
  parameter int unsigned CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ist_in_if.sink   in_i,
  ist_out_if.source out_o
);
  import ist_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [OpW-1:0]  op_q;
  logic [ElemW-1:0] elem_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic [ElemW-1:0] rdata_q;
  logic            present_q, present_d;
  logic            ovf_q, ovf_d;

  logic [ElemW-1:0] mem [CAPACITY];

  logic             accept;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             match;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [ElemW-1:0] wr_data;
  logic             load;
  logic             can_load;
  result_t          res;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign rd_en   = ((state_q == ST_SEARCH) || (state_q == ST_SHIFT)) && (iss_q < cnt_q);
  assign rd_addr = iss_q[IdxW-1:0];
  assign match   = chk_vld_q && (rdata_q == elem_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    iss_d     = rd_en ? iss_q + CntW'(1) : iss_q;
    chk_vld_d = rd_en;
    chk_idx_d = (state_q == ST_SHIFT) ? IdxW'(iss_q - CntW'(1)) : rd_addr;
    present_d = present_q;
    ovf_d     = ovf_q;
    wr_en     = 1'b0;
    wr_addr   = chk_idx_q;
    wr_data   = rdata_q;
    load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          iss_d     = '0;
          chk_vld_d = 1'b0;
          present_d = 1'b0;
          ovf_d     = 1'b0;
          state_d   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (match) begin
          present_d = 1'b1;
          if (op_q == OP_REMOVE) begin
            iss_d     = CntW'(chk_idx_q) + CntW'(1);
            chk_vld_d = 1'b0;
            state_d   = ST_SHIFT;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (!rd_en && !chk_vld_q) begin
          if (op_q == OP_ADD) begin
            if (cnt_q < CntW'(CAPACITY)) begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[IdxW-1:0];
              wr_data = elem_q;
              cnt_d   = cnt_q + CntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          state_d = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (chk_vld_q) begin
          wr_en = 1'b1;
        end
        if (!rd_en && !chk_vld_q) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      iss_q     <= '0;
      chk_vld_q <= 1'b0;
      present_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      chk_vld_q <= chk_vld_d;
      present_q <= present_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    if (accept) begin
      op_q   <= in_i.operation;
      elem_q <= in_i.element;
    end
  end

  // single read port, single write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    res.was_member   = present_q;
    res.member_count = CountW'(cnt_q);
    res.set_empty    = (cnt_q == '0);
    res.overflow     = ovf_q;
  end

  ist_result_reg u_result_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
